>>> hw/rtl/arrp_pkg.sv
package arrp_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RES_W       = SAMPLE_BITS + 1;
	localparam int PARAM_W     = 16;
	localparam int SUM_W       = 22;
	localparam int LEN_W       = 6;
	localparam int BLOCK_LEN_DEF = 32;

	localparam logic [1:0] CFG_STEREO_MODE = 2'd0;
	localparam logic [1:0] CFG_USE_FIXED   = 2'd1;
	localparam logic [1:0] CFG_FIXED_PARAM = 2'd2;

	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_RES   = 1'b1;

	typedef struct packed {
		logic             start;
		logic             clr;
		logic [LEN_W-1:0] len;
	} lane_ctl_t;

	typedef struct packed {
		logic               busy;
		logic [PARAM_W-1:0] m;
	} lane_stat_t;

endpackage

>>> hw/rtl/arrp_lane.sv
module arrp_lane
	import arrp_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	input  logic signed [SAMPLE_BITS-1:0] pred,
	input  lane_ctl_t                     ctl,
	output logic signed [RES_W-1:0]       res,
	output lane_stat_t                    stat
);

	logic [RES_W-1:0] mag;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] t_q;
	logic [SUM_W-1:0] m_q;
	logic             busy_q;
	logic             grow;

	assign res  = en ? ({smp[SAMPLE_BITS-1], smp} - {pred[SAMPLE_BITS-1], pred})
	                 : '0;
	assign mag  = res[RES_W-1] ? RES_W'(-res) : RES_W'(res);
	// next power of two still fits: sum >= len * 2m
	assign grow = {t_q, 1'b0} <= {1'b0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			t_q    <= '0;
			m_q    <= '0;
			busy_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				sum_q <= '0;
			end else if (acc) begin
				sum_q <= sum_q + SUM_W'(mag);
			end
			if (ctl.start) begin
				t_q    <= SUM_W'(ctl.len);
				m_q    <= SUM_W'(1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (grow) begin
					t_q <= {t_q[SUM_W-2:0], 1'b0};
					m_q <= {m_q[SUM_W-2:0], 1'b0};
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.m    = m_q[PARAM_W-1:0];

endmodule

>>> hw/rtl/arrp_merge.sv
module arrp_merge
	import arrp_pkg::*;
#(
	parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    acc,
	input  logic                    eos,
	input  logic signed [RES_W-1:0] res_l,
	input  logic signed [RES_W-1:0] res_r,
	input  lane_stat_t              stat_l,
	input  lane_stat_t              stat_r,
	input  logic                    stereo,
	input  logic                    use_fixed,
	input  logic [PARAM_W-1:0]      fixed_param,
	output logic                    busy,
	output lane_ctl_t               ctl,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    item_kind,
	output logic [PARAM_W-1:0]      param_left,
	output logic [PARAM_W-1:0]      param_right,
	output logic signed [RES_W-1:0] residual_left,
	output logic signed [RES_W-1:0] residual_right,
	output logic                    last_of_run
);

	localparam int FW = $clog2(BLOCK_LEN + 1);
	localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LAUNCH = 6'b000010,
		ST_WAIT   = 6'b000100,
		ST_PARAM  = 6'b001000,
		ST_RD     = 6'b010000,
		ST_LOAD   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       n_q;
	logic [AW-1:0]       idx_q;
	logic [2*RES_W-1:0]  mem [BLOCK_LEN];
	logic [2*RES_W-1:0]  rdata_q;
	logic                full;
	logic                ofree;
	logic                load;
	logic                last;
	logic [PARAM_W-1:0]  pl;
	logic [PARAM_W-1:0]  pr;

	logic                    ovalid_q;
	logic                    kind_q;
	logic [PARAM_W-1:0]      pl_q;
	logic [PARAM_W-1:0]      pr_q;
	logic signed [RES_W-1:0] rl_q;
	logic signed [RES_W-1:0] rr_q;
	logic                    last_q;

	assign full  = fill_q == FW'(BLOCK_LEN - 1);
	assign ofree = !ovalid_q || !out_stall;
	assign load  = ofree && (state_q == ST_PARAM || state_q == ST_LOAD);
	assign last  = (FW'(idx_q) + FW'(1)) == n_q;
	assign pl    = use_fixed ? fixed_param : stat_l.m;
	assign pr    = stereo ? (use_fixed ? fixed_param : stat_r.m) : '0;

	assign busy      = state_q != ST_IDLE;
	assign ctl.start = state_q == ST_LAUNCH;
	assign ctl.clr   = (state_q == ST_WAIT) && !stat_l.busy && !stat_r.busy;
	assign ctl.len   = LEN_W'(n_q);

	always_ff @(posedge clk) begin
		if (acc && state_q == ST_IDLE) begin
			mem[fill_q[AW-1:0]] <= {res_l, res_r};
		end
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (full || eos) begin
							n_q     <= fill_q + FW'(1);
							fill_q  <= '0;
							state_q <= ST_LAUNCH;
						end else begin
							fill_q <= fill_q + FW'(1);
						end
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (ctl.clr) begin
						state_q <= ST_PARAM;
					end
				end
				ST_PARAM: begin
					if (ofree) begin
						idx_q    <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (ofree) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PARAM && ofree) begin
			kind_q <= KIND_PARAM;
			pl_q   <= pl;
			pr_q   <= pr;
			rl_q   <= '0;
			rr_q   <= '0;
			last_q <= 1'b0;
		end else if (state_q == ST_LOAD && ofree) begin
			kind_q <= KIND_RES;
			pl_q   <= '0;
			pr_q   <= '0;
			rl_q   <= rdata_q[2*RES_W-1:RES_W];
			rr_q   <= rdata_q[RES_W-1:0];
			last_q <= last;
		end
	end

	assign out_valid      = ovalid_q;
	assign item_kind      = kind_q;
	assign param_left     = pl_q;
	assign param_right    = pr_q;
	assign residual_left  = rl_q;
	assign residual_right = rr_q;
	assign last_of_run    = last_q;

endmodule

>>> hw/rtl/audio_residual_and_rice_parameter.sv
// Frame without flush: taken with no result; next frame may follow at once.
// Flushing frame (block full or end of stream): the per-lane power-of-two search runs,
// then a parameter item and one residual item per frame of the block follow, each
// residual after a registered memory read; input stalls until the last is registered.
// Reset clears configuration to defaults, history, sums and fill count; the residual
// memory is not cleared, only entries written in the current block are read.
module audio_residual_and_rice_parameter
	import arrp_pkg::*;
#(
	parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [PARAM_W-1:0]            cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          item_kind,
	output logic [PARAM_W-1:0]            param_left,
	output logic [PARAM_W-1:0]            param_right,
	output logic signed [RES_W-1:0]       residual_left,
	output logic signed [RES_W-1:0]       residual_right,
	output logic                          last_of_run
);

	logic                          stereo_q;
	logic                          use_fixed_q;
	logic [PARAM_W-1:0]            fixed_q;
	logic signed [SAMPLE_BITS-1:0] prev_l_q;
	logic signed [SAMPLE_BITS-1:0] prev_r_q;
	logic                          start_q;
	logic                          busy;
	logic                          acc;
	logic signed [SAMPLE_BITS-1:0] pred_l;
	logic signed [SAMPLE_BITS-1:0] pred_r;
	logic signed [RES_W-1:0]       psum;
	logic signed [RES_W-1:0]       pround;
	logic signed [RES_W-1:0]       res_l;
	logic signed [RES_W-1:0]       res_r;
	lane_ctl_t                     ctl;
	lane_stat_t                    stat_l;
	lane_stat_t                    stat_r;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign acc       = in_valid && !busy;

	// right prediction: (prev_right + left) / 2, truncated toward zero
	assign psum   = {prev_r_q[SAMPLE_BITS-1], prev_r_q}
	              + {left_sample[SAMPLE_BITS-1], left_sample};
	assign pround = psum + RES_W'(psum[RES_W-1]);
	assign pred_l = start_q ? '0 : prev_l_q;
	assign pred_r = start_q ? '0 : pround[RES_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q    <= 1'b1;
			use_fixed_q <= 1'b0;
			fixed_q     <= PARAM_W'(1);
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			start_q     <= 1'b1;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_STEREO_MODE: stereo_q    <= cfg_data[0];
					CFG_USE_FIXED:   use_fixed_q <= cfg_data[0];
					CFG_FIXED_PARAM: fixed_q     <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				if (end_of_stream) begin
					prev_l_q <= '0;
					prev_r_q <= '0;
					start_q  <= 1'b1;
				end else begin
					prev_l_q <= left_sample;
					prev_r_q <= right_sample;
					start_q  <= 1'b0;
				end
			end
		end
	end

	arrp_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.en     (1'b1),
		.smp    (left_sample),
		.pred   (pred_l),
		.ctl    (ctl),
		.res    (res_l),
		.stat   (stat_l)
	);

	arrp_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.en     (stereo_q),
		.smp    (right_sample),
		.pred   (pred_r),
		.ctl    (ctl),
		.res    (res_r),
		.stat   (stat_r)
	);

	arrp_merge #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.acc            (acc),
		.eos            (end_of_stream),
		.res_l          (res_l),
		.res_r          (res_r),
		.stat_l         (stat_l),
		.stat_r         (stat_r),
		.stereo         (stereo_q),
		.use_fixed      (use_fixed_q),
		.fixed_param    (fixed_q),
		.busy           (busy),
		.ctl            (ctl),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.param_left     (param_left),
		.param_right    (param_right),
		.residual_left  (residual_left),
		.residual_right (residual_right),
		.last_of_run    (last_of_run)
	);

endmodule
